// ===== design/efr_pkg.sv =====
package efr_pkg;

  localparam int PROFILE_COUNT = 3;
  localparam int MAX_PAYLOAD   = 29;

  localparam int BYTE_W = 8;
  localparam int PLEN_W = 5;
  localparam int IDX_W  = 2;
  localparam int ST_W   = 2;
  localparam int SUM_W  = 16;

  localparam logic [BYTE_W-1:0] START_BYTE        = 8'hAA;
  localparam logic [BYTE_W-1:0] TYPE_EVENT        = 8'h57;
  localparam logic [BYTE_W-1:0] EVT_CONNECTION    = 8'hB3;
  localparam logic [BYTE_W-1:0] CODE_CONNECTED    = 8'h20;
  localparam logic [BYTE_W-1:0] CODE_DISCOVERABLE = 8'h21;
  localparam logic [BYTE_W-1:0] CODE_DISCONNECTED = 8'h23;
  localparam logic [BYTE_W-1:0] BYTE_MASK         = 8'hFF;

  localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd3;
  localparam logic [BYTE_W-1:0] MAX_LENGTH = 8'(MAX_PAYLOAD + 3);

  localparam logic [PLEN_W-1:0] TYPE_SKIP = 5'd4;
  localparam logic [PLEN_W-1:0] COMP_SKIP = 5'd2;

  typedef enum logic [ST_W-1:0] {
    ST_IDLE      = 2'd0,
    ST_PAIRING   = 2'd1,
    ST_CONNECTED = 2'd2
  } prof_state_t;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] event_code;
    logic [BYTE_W-1:0] transaction_id;
    logic [PLEN_W-1:0] payload_length;
    logic [BYTE_W-1:0] first_payload;
  } frame_t;

endpackage

// ===== design/efr_parser.sv =====
module efr_parser import efr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_in,
  output frame_t            frame
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_TYPE, PH_LEN, PH_COMP, PH_TRANS, PH_EVENT,
    PH_PAYLOAD, PH_SUM_LO, PH_SUM_HI, PH_TRAIL, PH_SKIP
  } phase_t;

  phase_t            phase;
  logic [BYTE_W-1:0] length_field;
  logic [PLEN_W-1:0] bytes_left;
  logic [SUM_W-1:0]  running_sum;
  logic [BYTE_W-1:0] held_transaction;
  logic [BYTE_W-1:0] held_event;
  logic [BYTE_W-1:0] held_first_payload;
  logic [BYTE_W-1:0] sum_low_byte;
  logic              sum_matches;

  logic [BYTE_W-1:0] plen_full;
  logic [PLEN_W-1:0] plen;
  logic              len_bad;

  assign plen_full = length_field - MIN_LENGTH;
  assign plen      = plen_full[PLEN_W-1:0];
  assign len_bad   = ((~length_field & BYTE_MASK) != byte_in) ||
                     (length_field < MIN_LENGTH) || (length_field > MAX_LENGTH);

  always_comb begin
    frame.done           = step && (phase == PH_TRAIL) && sum_matches;
    frame.event_code     = held_event;
    frame.transaction_id = held_transaction;
    frame.payload_length = plen;
    frame.first_payload  = held_first_payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      length_field       <= '0;
      bytes_left         <= '0;
      running_sum        <= '0;
      held_transaction   <= '0;
      held_event         <= '0;
      held_first_payload <= '0;
      sum_low_byte       <= '0;
      sum_matches        <= 1'b0;
    end else if (step) begin
      case (phase)
        PH_HUNT: begin
          if (byte_in == START_BYTE) phase <= PH_TYPE;
        end
        PH_TYPE: begin
          if (byte_in != TYPE_EVENT) begin
            bytes_left <= TYPE_SKIP;
            phase      <= PH_SKIP;
          end else begin
            phase <= PH_LEN;
          end
        end
        PH_LEN: begin
          length_field <= byte_in;
          phase        <= PH_COMP;
        end
        PH_COMP: begin
          if (len_bad) begin
            bytes_left <= COMP_SKIP;
            phase      <= PH_SKIP;
          end else begin
            phase <= PH_TRANS;
          end
        end
        PH_TRANS: begin
          held_transaction <= byte_in;
          phase            <= PH_EVENT;
        end
        PH_EVENT: begin
          held_event         <= byte_in;
          held_first_payload <= '0;
          running_sum        <= SUM_W'(byte_in);
          bytes_left         <= plen;
          phase              <= (plen != '0) ? PH_PAYLOAD : PH_SUM_LO;
        end
        PH_PAYLOAD: begin
          if (bytes_left == plen) held_first_payload <= byte_in;
          running_sum <= running_sum + SUM_W'(byte_in);
          if (bytes_left != '0) bytes_left <= bytes_left - 1'b1;
          if (bytes_left <= PLEN_W'(1)) phase <= PH_SUM_LO;
        end
        PH_SUM_LO: begin
          sum_low_byte <= byte_in;
          phase        <= PH_SUM_HI;
        end
        PH_SUM_HI: begin
          sum_matches <= ({byte_in, sum_low_byte} == running_sum);
          phase       <= PH_TRAIL;
        end
        PH_TRAIL: begin
          phase <= PH_HUNT;
        end
        PH_SKIP: begin
          if (bytes_left != '0) bytes_left <= bytes_left - 1'b1;
          if (bytes_left <= PLEN_W'(1)) phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

endmodule

// ===== design/efr_profile.sv =====
module efr_profile import efr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_data,
  input  frame_t            frame,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BYTE_W-1:0] event_code,
  output logic [BYTE_W-1:0] transaction_id,
  output logic [PLEN_W-1:0] payload_length,
  output logic [BYTE_W-1:0] first_payload_byte,
  output logic              ack_requested,
  output logic              state_changed,
  output logic [ST_W-1:0]   profile_state,
  output logic [IDX_W-1:0]  profile_index
);

  logic [IDX_W-1:0] active_profile;
  prof_state_t      profile_states [PROFILE_COUNT];

  prof_state_t cur;
  prof_state_t upd;
  logic        known;
  logic        ack;
  logic        changed;
  logic        has_payload;

  always_comb begin
    cur         = profile_states[active_profile];
    ack         = (frame.event_code == EVT_CONNECTION);
    has_payload = (frame.payload_length != '0);
    known       = 1'b1;
    upd         = cur;
    case (frame.first_payload)
      CODE_CONNECTED:    upd = ST_CONNECTED;
      CODE_DISCOVERABLE: upd = ST_PAIRING;
      CODE_DISCONNECTED: upd = ST_IDLE;
      default:           known = 1'b0;
    endcase
    changed = ack && has_payload && known && (upd != cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_profile <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < PROFILE_COUNT; i++) profile_states[i] <= ST_IDLE;
    end else begin
      if (cfg_write && (cfg_data < PROFILE_COUNT)) active_profile <= cfg_data;
      if (frame.done) begin
        out_valid <= 1'b1;
        if (changed) profile_states[active_profile] <= upd;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (frame.done) begin
      event_code         <= frame.event_code;
      transaction_id     <= frame.transaction_id;
      payload_length     <= frame.payload_length;
      first_payload_byte <= has_payload ? frame.first_payload : '0;
      ack_requested      <= ack;
      state_changed      <= changed;
      profile_state      <= changed ? upd : cur;
      profile_index      <= active_profile;
    end
  end

endmodule

// ===== design/module_event_frame_receiver_unit.sv =====
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready   | rx_byte
// out     | output    | out_valid / out_ready | event_code .. profile_index
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (active profile)
//
// one byte per cycle unless a result is stalled; a byte waits in the input register
// until taken, and a frame's result is registered in the cycle after its trailing byte is taken
// synchronous active-high reset; all profiles start idle, active profile 0
// cfg_ready is always high; out-of-range profile writes are ignored
// a stalled result holds the input register, and in_ready drops only then
module module_event_frame_receiver_unit import efr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] event_code,
  output logic [BYTE_W-1:0] transaction_id,
  output logic [PLEN_W-1:0] payload_length,
  output logic [BYTE_W-1:0] first_payload_byte,
  output logic              ack_requested,
  output logic              state_changed,
  output logic [ST_W-1:0]   profile_state,
  output logic [IDX_W-1:0]  profile_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_data
);

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_q;
  logic              step;
  frame_t            frame;

  assign step      = byte_valid && (!out_valid || out_ready);
  assign in_ready  = !byte_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) byte_q <= rx_byte;
  end

  efr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_q),
    .frame   (frame)
  );

  efr_profile u_profile (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .frame              (frame),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .event_code         (event_code),
    .transaction_id     (transaction_id),
    .payload_length     (payload_length),
    .first_payload_byte (first_payload_byte),
    .ack_requested      (ack_requested),
    .state_changed      (state_changed),
    .profile_state      (profile_state),
    .profile_index      (profile_index)
  );

endmodule

// ===== dv/module_event_frame_receiver_unit_test.sv =====
`timescale 1ns / 1ps

module module_event_frame_receiver_unit_test;
  import efr_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 255;

  typedef enum logic [3:0] {
    WAIT_START, WAIT_TYPE, GET_LEN, GET_LEN_INV, GET_TID, GET_EVENT,
    GET_PAYLOAD, GET_SUM_LO, GET_SUM_HI, GET_TRAILER, SKIP_HDR
  } rx_phase_t;

  typedef enum int {BRK_TYPE, BRK_INV, BRK_SHORT, BRK_LONG, BRK_CUT, BRK_NOISE} brk_kind_t;

  typedef struct {
    logic [BYTE_W-1:0] event_code;
    logic [BYTE_W-1:0] transaction_id;
    logic [PLEN_W-1:0] payload_length;
    logic [BYTE_W-1:0] first_payload;
    logic              ack;
    logic              changed;
    prof_state_t       state;
    logic [IDX_W-1:0]  index;
  } event_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] event_code;
  logic [BYTE_W-1:0] transaction_id;
  logic [PLEN_W-1:0] payload_length;
  logic [BYTE_W-1:0] first_payload_byte;
  logic              ack_requested;
  logic              state_changed;
  logic [ST_W-1:0]   profile_state;
  logic [IDX_W-1:0]  profile_index;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_data = '0;

  // frame tracker state
  rx_phase_t         frm_phase = WAIT_START;
  logic [BYTE_W-1:0] frm_len = '0;
  logic [PLEN_W-1:0] frm_left = '0;
  logic [SUM_W-1:0]  frm_sum = '0;
  logic [BYTE_W-1:0] frm_tid = '0;
  logic [BYTE_W-1:0] frm_evt = '0;
  logic [BYTE_W-1:0] frm_first = '0;
  logic [BYTE_W-1:0] frm_sum_lo = '0;
  logic              frm_sum_ok = 1'b0;
  prof_state_t       prof_state [PROFILE_COUNT] = '{default: ST_IDLE};
  logic [IDX_W-1:0]  cur_profile = '0;

  logic [BYTE_W-1:0] rx_queue [$];
  event_result_t     expected_events [$];
  logic [IDX_W-1:0]  cfg_plan [RAND_PHASES];

  bit quiet_phase = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;

  module_event_frame_receiver_unit u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_code         (event_code),
    .transaction_id     (transaction_id),
    .payload_length     (payload_length),
    .first_payload_byte (first_payload_byte),
    .ack_requested      (ack_requested),
    .state_changed      (state_changed),
    .profile_state      (profile_state),
    .profile_index      (profile_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    logic [PLEN_W-1:0] plen;
    prof_state_t       nxt;
    event_result_t     res;
    plen = PLEN_W'(frm_len - MIN_LENGTH);
    case (frm_phase)
      WAIT_START: begin
        if (b == START_BYTE) begin
          frm_phase = WAIT_TYPE;
        end
      end
      WAIT_TYPE: begin
        if (b != TYPE_EVENT) begin
          frm_left = TYPE_SKIP;
          frm_phase = SKIP_HDR;
        end else begin
          frm_phase = GET_LEN;
        end
      end
      GET_LEN: begin
        frm_len = b;
        frm_phase = GET_LEN_INV;
      end
      GET_LEN_INV: begin
        if (b != ~frm_len || frm_len < MIN_LENGTH || frm_len > MAX_LENGTH) begin
          frm_left = COMP_SKIP;
          frm_phase = SKIP_HDR;
        end else begin
          frm_phase = GET_TID;
        end
      end
      GET_TID: begin
        frm_tid = b;
        frm_phase = GET_EVENT;
      end
      GET_EVENT: begin
        frm_evt = b;
        frm_first = '0;
        frm_sum = SUM_W'(b);
        frm_left = plen;
        frm_phase = (plen != 0) ? GET_PAYLOAD : GET_SUM_LO;
      end
      GET_PAYLOAD: begin
        if (frm_left == plen) begin
          frm_first = b;
        end
        frm_sum = frm_sum + SUM_W'(b);
        if (frm_left != 0) begin
          frm_left--;
        end
        if (frm_left == 0) begin
          frm_phase = GET_SUM_LO;
        end
      end
      GET_SUM_LO: begin
        frm_sum_lo = b;
        frm_phase = GET_SUM_HI;
      end
      GET_SUM_HI: begin
        frm_sum_ok = ({b, frm_sum_lo} == frm_sum);
        frm_phase = GET_TRAILER;
      end
      GET_TRAILER: begin
        frm_phase = WAIT_START;
        if (frm_sum_ok) begin
          res.event_code = frm_evt;
          res.transaction_id = frm_tid;
          res.payload_length = plen;
          res.first_payload = (plen != 0) ? frm_first : '0;
          res.ack = (frm_evt == EVT_CONNECTION);
          nxt = prof_state[cur_profile];
          if (res.ack && plen != 0) begin
            case (frm_first)
              CODE_CONNECTED:    nxt = ST_CONNECTED;
              CODE_DISCOVERABLE: nxt = ST_PAIRING;
              CODE_DISCONNECTED: nxt = ST_IDLE;
              default: ;
            endcase
          end
          res.changed = (nxt != prof_state[cur_profile]);
          prof_state[cur_profile] = nxt;
          res.state = nxt;
          res.index = cur_profile;
          expected_events.push_back(res);
        end
      end
      SKIP_HDR: begin
        if (frm_left != 0) begin
          frm_left--;
        end
        if (frm_left == 0) begin
          frm_phase = WAIT_START;
        end
      end
      default: begin
        frm_phase = WAIT_START;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic add_frame(input logic [BYTE_W-1:0] evt, input logic [BYTE_W-1:0] tid,
                           input int plen, input logic [BYTE_W-1:0] first, input bit bad_sum);
    logic [BYTE_W-1:0] len;
    logic [SUM_W-1:0]  sum;
    logic [BYTE_W-1:0] pb;
    len = BYTE_W'(plen + 3);
    sum = SUM_W'(evt);
    rx_queue.push_back(START_BYTE);
    rx_queue.push_back(TYPE_EVENT);
    rx_queue.push_back(len);
    rx_queue.push_back(~len);
    rx_queue.push_back(tid);
    rx_queue.push_back(evt);
    for (int i = 0; i < plen; i++) begin
      pb = (i == 0) ? first : BYTE_W'($urandom);
      sum = sum + SUM_W'(pb);
      rx_queue.push_back(pb);
    end
    if (bad_sum) begin
      sum = sum ^ SUM_W'($urandom_range(1, 65535));
    end
    rx_queue.push_back(sum[7:0]);
    rx_queue.push_back(sum[15:8]);
    rx_queue.push_back(BYTE_W'($urandom));
  endtask

  task automatic add_header(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] inv);
    rx_queue.push_back(START_BYTE);
    rx_queue.push_back(TYPE_EVENT);
    rx_queue.push_back(len);
    rx_queue.push_back(inv);
    rx_queue.push_back(BYTE_W'($urandom));
    rx_queue.push_back(BYTE_W'($urandom));
  endtask

  task automatic add_random_frame(input bit bad_sum);
    int                r;
    int                plen;
    logic [BYTE_W-1:0] evt;
    logic [BYTE_W-1:0] first;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      plen = $urandom_range(0, 6);
    end else if (r < 95) begin
      plen = $urandom_range(7, MAX_PAYLOAD - 1);
    end else begin
      plen = MAX_PAYLOAD;
    end
    evt = ($urandom_range(0, 1) == 1) ? EVT_CONNECTION : BYTE_W'($urandom);
    case ($urandom_range(0, 4))
      0: first = CODE_CONNECTED;
      1: first = CODE_DISCOVERABLE;
      2: first = CODE_DISCONNECTED;
      default: first = BYTE_W'($urandom);
    endcase
    add_frame(evt, BYTE_W'($urandom), plen, first, bad_sum);
  endtask

  task automatic add_broken(input brk_kind_t kind);
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] hdr [7];
    int                n;
    case (kind)
      BRK_TYPE: begin
        do t = BYTE_W'($urandom); while (t == TYPE_EVENT);
        rx_queue.push_back(START_BYTE);
        rx_queue.push_back(t);
        repeat (4) rx_queue.push_back(BYTE_W'($urandom));
      end
      BRK_INV: begin
        len = BYTE_W'($urandom_range(MIN_LENGTH, MAX_LENGTH));
        add_header(len, ~len ^ BYTE_W'($urandom_range(1, 255)));
      end
      BRK_SHORT: begin
        len = BYTE_W'($urandom_range(0, MIN_LENGTH - 1));
        add_header(len, ~len);
      end
      BRK_LONG: begin
        len = BYTE_W'($urandom_range(MAX_LENGTH + 1, 255));
        add_header(len, ~len);
      end
      BRK_CUT: begin
        len = BYTE_W'($urandom_range(MIN_LENGTH, MAX_LENGTH));
        hdr = '{START_BYTE, TYPE_EVENT, len, ~len, BYTE_W'($urandom), BYTE_W'($urandom),
                BYTE_W'($urandom)};
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) begin
          rx_queue.push_back(hdr[i]);
        end
      end
      default: begin
        repeat ($urandom_range(1, 6)) rx_queue.push_back(BYTE_W'($urandom));
      end
    endcase
  endtask

  task automatic write_profile(input logic [IDX_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (value < PROFILE_COUNT) begin
      cur_profile = value;
    end
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rx_queue.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_rx_byte(rx_byte);
        bytes_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (rx_queue.size() != 0) begin
        in_valid <= 1'b1;
        rx_byte <= rx_queue.pop_front();
        send_gap = quiet_phase ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    event_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("result with none expected: event_code %0h", event_code);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_code", 16'(want.event_code), 16'(event_code));
          check_field("transaction_id", 16'(want.transaction_id), 16'(transaction_id));
          check_field("payload_length", 16'(want.payload_length), 16'(payload_length));
          check_field("first_payload_byte", 16'(want.first_payload),
                      16'(first_payload_byte));
          check_field("ack_requested", 16'(want.ack), 16'(ack_requested));
          check_field("state_changed", 16'(want.changed), 16'(state_changed));
          check_field("profile_state", 16'(want.state), 16'(profile_state));
          check_field("profile_index", 16'(want.index), 16'(profile_index));
          results_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 99) < 15) begin
        stall_left = idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("module_event_frame_receiver_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_profile(2'd1);
    @(negedge clk);

    // directed frames
    add_frame(8'h00, 8'h00, 0, 8'h00, 1'b0);
    add_frame(8'hFF, 8'hFF, MAX_PAYLOAD, 8'hFF, 1'b0);
    add_frame(EVT_CONNECTION, 8'h01, 1, CODE_DISCOVERABLE, 1'b0);
    add_frame(EVT_CONNECTION, 8'h02, 1, CODE_DISCOVERABLE, 1'b0);
    add_frame(EVT_CONNECTION, 8'h03, 3, CODE_CONNECTED, 1'b0);
    add_frame(EVT_CONNECTION, 8'h04, 2, 8'h55, 1'b0);
    add_frame(EVT_CONNECTION, 8'h05, 0, 8'h00, 1'b0);
    add_frame(EVT_CONNECTION, 8'h06, 2, CODE_DISCONNECTED, 1'b0);
    add_frame(EVT_CONNECTION, 8'h07, 1, CODE_CONNECTED, 1'b1);
    // start bytes inside a rejected header are not new frames
    repeat (6) rx_queue.push_back(START_BYTE);
    add_frame(EVT_CONNECTION, 8'h08, 1, CODE_CONNECTED, 1'b0);
    add_header(8'd2, ~8'd2);
    add_header(8'd0, 8'hFF);
    add_header(MAX_LENGTH + 8'd1, ~(MAX_LENGTH + 8'd1));
    add_header(8'hFF, 8'h00);
    add_header(8'd5, 8'd5);
    add_frame(8'h5A, 8'hA5, 2, CODE_CONNECTED, 1'b0);
    wait_idle();

    cfg_plan = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd2, IDX_W'($urandom_range(0, 3))};
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_profile(cfg_plan[p]);
      @(negedge clk);
      quiet_phase = (p == 2);
      while (rx_queue.size() < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          add_random_frame(1'b0);
        end else if (r < 80) begin
          add_random_frame(1'b1);
        end else begin
          add_broken(brk_kind_t'($urandom_range(0, 5)));
        end
      end
      wait_idle();
    end

    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      error_count++;
    end
    $display("sent %0d bytes, checked %0d frame results, %0d profile register writes",
             bytes_sent, results_checked, cfg_writes);
    $display("mixed good, bad-sum, rejected-header and cut-off frames under every profile");
    if (error_count == 0) begin
      $display("module_event_frame_receiver_unit_test OK");
    end else begin
      $display("module_event_frame_receiver_unit_test NOT OK");
    end
    $finish;
  end

endmodule
